// ----- design/lea128_block_encrypt_defines.svh -----
// assertion macros shared by the lea128 rtl
`ifndef LEA128_BLOCK_ENCRYPT_DEFINES_SVH
`define LEA128_BLOCK_ENCRYPT_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LEA128_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lea128 check failed");

// next-cycle implication, checked on every rising edge out of reset
`define LEA128_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lea128 check failed");

`endif

// ----- design/lea128_pkg.sv -----
// shared types, constants and round functions of the lea-128 encrypt pipeline
package lea128_pkg;

    localparam int unsigned ROUND_COUNT = 24;

    typedef logic [31:0] t_word;
    typedef t_word [3:0] t_quad;

    // block words and key schedule words that travel down the pipeline together
    typedef struct packed {
        t_quad x;
        t_quad t;
    } t_state;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx IDX_KEY_WORD0 = 3'd0;
    localparam t_cfg_idx IDX_KEY_WORD1 = 3'd1;
    localparam t_cfg_idx IDX_KEY_WORD2 = 3'd2;
    localparam t_cfg_idx IDX_KEY_WORD3 = 3'd3;

    localparam t_word DELTA0 = 32'hc3efe9db;
    localparam t_word DELTA1 = 32'h88c4d604;
    localparam t_word DELTA2 = 32'he789f229;
    localparam t_word DELTA3 = 32'hc6f98763;
    localparam t_quad LEA_DELTA = {DELTA3, DELTA2, DELTA1, DELTA0};

    function automatic t_word rotl(input t_word v, input logic [4:0] n);
        rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_word rotr(input t_word v, input logic [4:0] n);
        rotr = rotl(v, 5'd0 - n);
    endfunction

    // delta used by round r: base word r mod 4, rotated left by 4 per earlier use
    function automatic t_word round_delta(input int unsigned r);
        logic [4:0] amt;
        amt = 5'((r >> 2) << 2);
        round_delta = rotl(LEA_DELTA[r[1:0]], amt);
    endfunction

    function automatic t_quad key_step(input t_quad t, input t_word d);
        t_quad k;
        k[0] = rotl(t[0] + d, 5'd1);
        k[1] = rotl(t[1] + rotl(d, 5'd1), 5'd3);
        k[2] = rotl(t[2] + rotl(d, 5'd2), 5'd6);
        k[3] = rotl(t[3] + rotl(d, 5'd3), 5'd11);
        key_step = k;
    endfunction

    // round keys are t0,t1,t2,t1,t3,t1
    function automatic t_quad mix(input t_quad x, input t_quad t);
        t_quad y;
        y[0] = rotl((x[0] ^ t[0]) + (x[1] ^ t[1]), 5'd9);
        y[1] = rotr((x[1] ^ t[2]) + (x[2] ^ t[1]), 5'd5);
        y[2] = rotr((x[2] ^ t[3]) + (x[3] ^ t[1]), 5'd3);
        y[3] = x[0];
        mix = y;
    endfunction

endpackage

// ----- design/lea128_round.sv -----
// one round stage: block mix for this round and key schedule for the next
module lea128_round #(
    parameter int unsigned RND_IDX  = 0,
    parameter bit          HAS_NEXT = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  lea128_pkg::t_state  i_st,
    output logic                o_vld,
    output lea128_pkg::t_state  o_st
);
    import lea128_pkg::*;

    t_state n_st;
    t_state r_st;
    logic   r_vld;

    // schedule no longer needed after the final round, so it just passes through
    always_comb begin
        n_st.x = mix(i_st.x, i_st.t);
        n_st.t = HAS_NEXT ? key_step(i_st.t, round_delta(RND_IDX + 1)) : i_st.t;
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ----- design/lea128_block_encrypt.sv -----
// top level of the lea-128 block encrypt pipeline
//
//  channel   direction  ports                                  handshake
//  -------   ---------  -------------------------------------  ---------------------------
//  input     in         i_plain_word0..3                       i_start & !o_busy
//  result    out        o_cipher_word0..3                      o_valid, one cycle strobe
//  config    in         i_cfg_idx, i_cfg_data                  i_cfg_we, no wait
//
//  one item per cycle once o_busy is low; a taken block passes through the register stages
//  (one stage for the first key schedule step, then one register stage per round)
//  each round stage holds one 32-bit add/xor/rotate for the mix, all but the last one for the key too
//  o_busy is high during reset and the cycle after it, low from then on
//  results cannot be held off, so the pipeline never stalls
`include "lea128_block_encrypt_defines.svh"

module lea128_block_encrypt #(
    parameter int unsigned ROUND_COUNT = lea128_pkg::ROUND_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  lea128_pkg::t_cfg_idx   i_cfg_idx,
    input  lea128_pkg::t_word      i_cfg_data,
    // input item
    input  logic                   i_start,
    output logic                   o_busy,
    input  lea128_pkg::t_word      i_plain_word0,
    input  lea128_pkg::t_word      i_plain_word1,
    input  lea128_pkg::t_word      i_plain_word2,
    input  lea128_pkg::t_word      i_plain_word3,
    // result item
    output logic                   o_valid,
    output lea128_pkg::t_word      o_cipher_word0,
    output lea128_pkg::t_word      o_cipher_word1,
    output lea128_pkg::t_word      o_cipher_word2,
    output lea128_pkg::t_word      o_cipher_word3
);
    import lea128_pkg::*;

    // key registers, untouched by encryption
    t_quad  r_key;
    // comes up in the cycle after reset so that no item is taken during reset
    logic   r_rdy;
    logic   w_accept;

    // entry stage: plaintext plus key schedule after its first step
    logic   r_vld0;
    t_state r_st0;
    t_state n_st0;

    // stage k output feeds round k; the last entry is the finished block
    logic   [ROUND_COUNT:0] w_vld;
    t_state                 w_st [0:ROUND_COUNT];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                IDX_KEY_WORD0: r_key[0] <= i_cfg_data;
                IDX_KEY_WORD1: r_key[1] <= i_cfg_data;
                IDX_KEY_WORD2: r_key[2] <= i_cfg_data;
                IDX_KEY_WORD3: r_key[3] <= i_cfg_data;
                default:       r_key    <= r_key;    // writes past the key are dropped
            endcase
        end
    end

    // ---------------- input handshake ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign o_busy   = !r_rdy;
    assign w_accept = i_start && r_rdy;

    // ---------------- entry stage ----------------
    always_comb begin
        n_st0.x = {i_plain_word3, i_plain_word2, i_plain_word1, i_plain_word0};
        n_st0.t = key_step(r_key, round_delta(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_st0 <= n_st0;
        end
    end

    assign w_vld[0] = r_vld0;
    assign w_st[0]  = r_st0;

    // ---------------- round stages ----------------
    // round k mixes with schedule k and, but for the last round, derives schedule k+1 in the same stage
    generate
        for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
            lea128_round #(
                .RND_IDX  (k),
                .HAS_NEXT (k < ROUND_COUNT - 1)
            ) u_round (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_vld[k]),
                .i_st    (w_st[k]),
                .o_vld   (w_vld[k+1]),
                .o_st    (w_st[k+1])
            );
        end
    endgenerate

    // ---------------- result ----------------
    // final round registers drive the ports directly
    assign o_valid        = w_vld[ROUND_COUNT];
    assign o_cipher_word0 = w_st[ROUND_COUNT].x[0];
    assign o_cipher_word1 = w_st[ROUND_COUNT].x[1];
    assign o_cipher_word2 = w_st[ROUND_COUNT].x[2];
    assign o_cipher_word3 = w_st[ROUND_COUNT].x[3];

    // ---------------- checks ----------------
    `LEA128_ASSERT_NEXT(a_accept_enters, w_accept, r_vld0)
    `LEA128_ASSERT_NEXT(a_busy_blocks, o_busy, !r_vld0)
    `LEA128_ASSERT_NEXT(a_last_round_out, w_vld[ROUND_COUNT-1], o_valid)
    `LEA128_ASSERT_NEXT(a_no_stray_out, !w_vld[ROUND_COUNT-1], !o_valid)

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the lea-128 block encrypt pipeline
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lea128_pkg::*;

    localparam int unsigned LATENCY      = ROUND_COUNT + 1;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned KEY_PHASES   = 6;
    localparam int unsigned PHASE_ITEMS  = 275;
    localparam int unsigned MAX_REPORTS  = 10;
    // slowest run: every item after the longest gap
    localparam int unsigned LIMIT_CYCLES = 400000;
    // first register index that maps to no key word
    localparam t_cfg_idx IDX_FIRST_UNUSED = IDX_KEY_WORD3 + 3'd1;
    localparam t_cfg_idx IDX_LAST         = '1;

    // keeps the key copy, computes each ciphertext and holds it until it comes out
    class lea_cipher_board;
        t_quad       key_words;
        t_quad       pending_cipher[$];
        int unsigned blocks_taken;
        int unsigned ciphers_seen;
        int unsigned error_count;

        function new();
            key_words      = '0;
            blocks_taken   = 0;
            ciphers_seen   = 0;
            error_count    = 0;
        endfunction

        function t_word rol32(t_word v, int unsigned n);
            return (v << n) | (v >> (32 - n));
        endfunction

        // out-of-range indexes leave the key alone
        function void set_key(t_cfg_idx idx, t_word data);
            if (idx <= IDX_KEY_WORD3) begin
                key_words[idx] = data;
            end
        endfunction

        function t_quad encrypt(t_quad plain);
            t_quad       dl;
            t_quad       tk;
            t_quad       x;
            t_word       dv;
            t_word       x0;
            int unsigned r;
            dl = LEA_DELTA;
            tk = key_words;
            x  = plain;
            for (r = 0; r < ROUND_COUNT; r++) begin
                // each delta word is rotated by 4 after every use
                dv         = dl[r % 4];
                dl[r % 4]  = rol32(dv, 4);
                tk[0]      = rol32(tk[0] + dv, 1);
                tk[1]      = rol32(tk[1] + rol32(dv, 1), 3);
                tk[2]      = rol32(tk[2] + rol32(dv, 2), 6);
                tk[3]      = rol32(tk[3] + rol32(dv, 3), 11);
                x0         = x[0];
                x[0]       = rol32((x[0] ^ tk[0]) + (x[1] ^ tk[1]), 9);
                // right rotations written as left rotations by 32 - n
                x[1]       = rol32((x[1] ^ tk[2]) + (x[2] ^ tk[1]), 27);
                x[2]       = rol32((x[2] ^ tk[3]) + (x[3] ^ tk[1]), 29);
                x[3]       = x0;
            end
            return x;
        endfunction

        function void note_plain(t_quad plain);
            pending_cipher.push_back(encrypt(plain));
            blocks_taken++;
        endfunction

        function void report(string msg);
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void check_cipher(t_quad got);
            t_quad       want;
            int unsigned w;
            if (pending_cipher.size() == 0) begin
                report($sformatf("ciphertext %08h %08h %08h %08h with no block pending",
                                 got[0], got[1], got[2], got[3]));
                return;
            end
            want = pending_cipher.pop_front();
            for (w = 0; w < 4; w++) begin
                if (got[w] !== want[w]) begin
                    report($sformatf("block %0d cipher_word%0d expected %08h got %08h",
                                     ciphers_seen, w, want[w], got[w]));
                end
            end
            ciphers_seen++;
        endfunction

        function int unsigned pending();
            return pending_cipher.size();
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_word i_cfg_data;
    logic  i_start;
    logic  o_busy;
    t_word i_plain_word0;
    t_word i_plain_word1;
    t_word i_plain_word2;
    t_word i_plain_word3;
    logic  o_valid;
    t_word o_cipher_word0;
    t_word o_cipher_word1;
    t_word o_cipher_word2;
    t_word o_cipher_word3;

    lea_cipher_board sb;
    int unsigned     cycle_count = 0;
    int unsigned     key_settings = 0;
    // items left in a run with no idling between them
    int unsigned     burst_left = 0;

    lea128_block_encrypt u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_plain_word0 (i_plain_word0),
        .i_plain_word1 (i_plain_word1),
        .i_plain_word2 (i_plain_word2),
        .i_plain_word3 (i_plain_word3),
        .o_valid       (o_valid),
        .o_cipher_word0(o_cipher_word0),
        .o_cipher_word1(o_cipher_word1),
        .o_cipher_word2(o_cipher_word2),
        .o_cipher_word3(o_cipher_word3)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // results cannot be held off: every strobe is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            sb.check_cipher({o_cipher_word3, o_cipher_word2, o_cipher_word1,
                             o_cipher_word0});
        end
    end

    // hard stop in case the pipeline hangs or strobes stop coming
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
        end
        $display("timeout after %0d cycles with %0d blocks pending",
                 cycle_count, sb.pending());
        $display("tb: errors");
        $finish;
    end

    // word with extreme values mixed in so every bit sees both levels often
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, 31);
            3:       return ~(t_word'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // mostly short gaps, a few long ones, and now and then a gapless run
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // offer one block, hold it until taken, then idle for a random gap
    task automatic send_block(t_quad plain);
        int unsigned gap;
        i_start       <= 1'b1;
        i_plain_word0 <= plain[0];
        i_plain_word1 <= plain[1];
        i_plain_word2 <= plain[2];
        i_plain_word3 <= plain[3];
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        sb.note_plain(plain);
        gap = pick_gap();
        if (gap != 0) begin
            // junk on the data lines while start is low
            i_start       <= 1'b0;
            i_plain_word0 <= $urandom;
            i_plain_word1 <= $urandom;
            i_plain_word2 <= $urandom;
            i_plain_word3 <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let every pending ciphertext come out, then idle for longer than a block takes to pass through
    task automatic wait_idle();
        i_start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // write all key words plus one index that maps to nothing
    task automatic program_keys(t_quad k);
        int unsigned w;
        t_word       junk;
        for (w = 0; w < 4; w++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(IDX_KEY_WORD0 + w);
            i_cfg_data <= k[w];
            @(posedge i_clk);
            sb.set_key(t_cfg_idx'(IDX_KEY_WORD0 + w), k[w]);
        end
        junk        = pick_word();
        i_cfg_idx  <= t_cfg_idx'($urandom_range(IDX_FIRST_UNUSED, IDX_LAST));
        i_cfg_data <= junk;
        @(posedge i_clk);
        sb.set_key(i_cfg_idx, junk);
        i_cfg_we <= 1'b0;
        key_settings++;
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned n;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = IDX_KEY_WORD0;
        i_cfg_data    = '0;
        i_start       = 1'b0;
        i_plain_word0 = '0;
        i_plain_word1 = '0;
        i_plain_word2 = '0;
        i_plain_word3 = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key from reset: all zero, with plaintext extremes
        send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_block({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_block({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_block({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_block({32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
        send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
        send_block({32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_block({32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000});
        wait_idle();

        // key all ones, carry chains through the schedule adds
        program_keys({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_block({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_block({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
        send_block({32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001});
        wait_idle();

        // published-style key and plaintext words, then alternating key bits
        program_keys({32'hc3d2_e1f0, 32'h8796_a5b4, 32'h4b5a_6978, 32'h0f1e_2d3c});
        send_block({32'h1f1e_1d1c, 32'h1b1a_1918, 32'h1716_1514, 32'h1312_1110});
        send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_block({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        wait_idle();
        program_keys({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
        send_block({32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff});
        send_block({32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000});
        wait_idle();

        // random keys per phase, random blocks inside each phase
        for (ph = 0; ph < KEY_PHASES; ph++) begin
            program_keys({pick_word(), pick_word(), pick_word(), pick_word()});
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_block({pick_word(), pick_word(), pick_word(), pick_word()});
            end
            wait_idle();
        end

        // anything still waiting never came out
        if (sb.pending() != 0) begin
            $display("%0d blocks never produced a ciphertext", sb.pending());
            sb.error_count += sb.pending();
        end
        $display("summary: %0d blocks encrypted under %0d key settings, %0d checked",
                 sb.blocks_taken, key_settings + 1, sb.ciphers_seen);
        $display("summary: %0d mismatches in %0d cycles", sb.error_count, cycle_count);
        if (sb.error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
